@@ sv/life_generation_row_stream_assert.svh @@
// ----------------------------------------------------------------------------
// Life generation row stream - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef LIFE_GENERATION_ROW_STREAM_ASSERT_SVH
`define LIFE_GENERATION_ROW_STREAM_ASSERT_SVH

// same-cycle implication
`define LGRS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error("lgrs assertion failed");

// next-cycle implication
`define LGRS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error("lgrs assertion failed");

`endif

@@ sv/lgrs_pkg.sv @@
// ----------------------------------------------------------------------------
// lgrs_pkg
// Types and constants shared by the life generation row stream block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

    localparam int ROW_BITS = 64;
    localparam int CFG_BITS = 7;
    localparam logic [CFG_BITS-1:0] GRID_WIDTH_RESET = 7'd64;

    // B3/S23 neighbor counts
    localparam logic [3:0] BORN_COUNT    = 4'd3;
    localparam logic [3:0] SURVIVE_COUNT = 4'd2;

    // rows buffered in the current grid (saturating)
    localparam logic [1:0] SEEN_NONE = 2'd0;
    localparam logic [1:0] SEEN_ONE  = 2'd1;
    localparam logic [1:0] SEEN_TWO  = 2'd2;

    // result queue
    localparam int OUT_DEPTH = 4;
    localparam int OUT_PTR_W = 2;
    localparam int OUT_CNT_W = 3;

    typedef struct packed {
        logic [ROW_BITS-1:0] row_cells;
        logic                is_last_row;
    } t_row_in;

    typedef struct packed {
        logic [ROW_BITS-1:0] next_row_cells;
        logic                last_of_grid;
    } t_row_out;

    // push requests from the merge stage into the result queue
    typedef struct packed {
        logic push_first;
        logic push_second;
    } t_push;

endpackage

`default_nettype wire

@@ sv/lgrs_lane.sv @@
// ----------------------------------------------------------------------------
// lgrs_lane
// One cell of B3/S23: counts the 3x3 neighborhood and gives the next state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgrs_lane
    import lgrs_pkg::*;
(
    input  wire logic [2:0] i_up,
    input  wire logic [2:0] i_mid,
    input  wire logic [2:0] i_down,
    output logic            o_alive
);

    logic [3:0] w_count;

    // eight neighbors, center excluded
    assign w_count = {3'd0, i_up[0]}   + {3'd0, i_up[1]}   + {3'd0, i_up[2]}
                   + {3'd0, i_mid[0]}                      + {3'd0, i_mid[2]}
                   + {3'd0, i_down[0]} + {3'd0, i_down[1]} + {3'd0, i_down[2]};

    assign o_alive = (w_count == BORN_COUNT) || (i_mid[1] && (w_count == SURVIVE_COUNT));

endmodule

`default_nettype wire

@@ sv/lgrs_merge.sv @@
// ----------------------------------------------------------------------------
// lgrs_merge
// Gathers the lane outputs into zero, one or two ordered result rows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgrs_merge
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                 i_accept,
    input  wire logic                 i_is_last,
    input  wire logic [1:0]           i_rows_seen,
    input  wire logic [MAX_WIDTH-1:0] i_mask,
    input  wire logic [MAX_WIDTH-1:0] i_lanes_above,
    input  wire logic [MAX_WIDTH-1:0] i_lanes_cur,
    output t_push                     o_push,
    output t_row_out                  o_first,
    output t_row_out                  o_second
);

    t_row_out w_above;
    t_row_out w_cur;
    logic     w_have_above;

    // pack masked lane results into full-width rows
    always_comb begin
        w_above = '0;
        w_cur   = '0;
        w_above.next_row_cells[MAX_WIDTH-1:0] = i_lanes_above & i_mask;
        w_cur.next_row_cells[MAX_WIDTH-1:0]   = i_lanes_cur & i_mask;
        w_above.last_of_grid = 1'b0;
        w_cur.last_of_grid   = 1'b1;
    end

    assign w_have_above = (i_rows_seen != SEEN_NONE);

    // row above goes first; the last row follows it
    assign o_push.push_first  = i_accept && (w_have_above || i_is_last);
    assign o_push.push_second = i_accept && w_have_above && i_is_last;
    assign o_first            = w_have_above ? w_above : w_cur;
    assign o_second           = w_cur;

endmodule

`default_nettype wire

@@ sv/lgrs_out_fifo.sv @@
// ----------------------------------------------------------------------------
// lgrs_out_fifo
// Small result queue: takes up to two results per cycle, gives one.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lgrs_out_fifo
    import lgrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_push    i_push,
    input  wire t_row_out i_first,
    input  wire t_row_out i_second,
    input  wire logic     i_pop,
    output logic          o_valid,
    output t_row_out      o_data,
    output logic          o_room_two
);

    t_row_out             r_mem [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] r_wr_ptr;
    logic [OUT_PTR_W-1:0] r_rd_ptr;
    logic [OUT_CNT_W-1:0] r_count;
    logic [OUT_PTR_W-1:0] n_wr_ptr;
    logic [OUT_CNT_W-1:0] n_count;
    logic [OUT_PTR_W-1:0] w_wr_next;
    logic [OUT_CNT_W-1:0] w_pushes;

    assign w_wr_next = OUT_PTR_W'(r_wr_ptr + 1'b1);
    assign w_pushes  = OUT_CNT_W'(i_push.push_first) + OUT_CNT_W'(i_push.push_second);
    assign n_wr_ptr  = OUT_PTR_W'(r_wr_ptr + w_pushes[OUT_PTR_W-1:0]);
    assign n_count   = OUT_CNT_W'(r_count + w_pushes - OUT_CNT_W'(i_pop));

    // storage (no reset on payload)
    always_ff @(posedge i_clk) begin
        if (i_push.push_first) begin
            r_mem[r_wr_ptr] <= i_first;
        end
        if (i_push.push_second) begin
            r_mem[w_wr_next] <= i_second;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_count  <= n_count;
            if (i_pop) begin
                r_rd_ptr <= OUT_PTR_W'(r_rd_ptr + 1'b1);
            end
        end
    end

    assign o_valid    = (r_count != '0);
    assign o_data     = r_mem[r_rd_ptr];
    assign o_room_two = (r_count <= OUT_CNT_W'(OUT_DEPTH - 2));

endmodule

`default_nettype wire

@@ sv/life_generation_row_stream.sv @@
// ----------------------------------------------------------------------------
// life_generation_row_stream
// One B3/S23 Game of Life generation over a row stream, dead border.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_stall / i_row): one grid row per transaction,
//   top to bottom, is_last_row set on the bottom row. Output channel
//   (o_valid / i_stall / o_res): next-generation rows in grid order, the
//   bottom one marked last_of_grid.
//   Each row after the first yields the new row above it; the bottom row also
//   yields itself, so it produces two transactions (a lone row yields one).
//   Latency: a result is visible the cycle after its input transaction when no
//   older result is queued. Throughput: one row per cycle while o_stall is low,
//   set by the per-column lane array; the one output port drains a bottom row's
//   two results one after another, so a grid of N rows gives N results.
//   A 4-entry result queue sits between the sides; o_stall rises when it
//   cannot take two more results, so a stalled receiver holds the input off
//   after at most a few rows. i_cfg_we writes grid_width (idle only).
//   Reset clears buffered rows and the queue and sets grid_width to 64.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_stream
    import lgrs_pkg::*;
#(
    parameter int MAX_WIDTH = 64
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_stall,
    input  wire t_row_in             i_row,
    output logic                     o_valid,
    input  wire logic                i_stall,
    output t_row_out                 o_res,
    input  wire logic                i_cfg_we,
    input  wire logic [CFG_BITS-1:0] i_cfg_wdata
);

    logic [CFG_BITS-1:0]  r_grid_width;
    logic [MAX_WIDTH-1:0] r_row_above;
    logic [MAX_WIDTH-1:0] r_row_two_above;
    logic [1:0]           r_rows_seen;

    logic [MAX_WIDTH-1:0] w_mask;
    logic [MAX_WIDTH-1:0] w_cur;
    logic [MAX_WIDTH-1:0] w_up_a;
    logic [MAX_WIDTH-1:0] w_up_b;
    logic [MAX_WIDTH+1:0] w_pad_up_a;
    logic [MAX_WIDTH+1:0] w_pad_mid_a;
    logic [MAX_WIDTH+1:0] w_pad_up_b;
    logic [MAX_WIDTH+1:0] w_pad_mid_b;
    logic [MAX_WIDTH-1:0] w_lanes_above;
    logic [MAX_WIDTH-1:0] w_lanes_cur;
    logic                 w_accept;
    logic                 w_room_two;
    t_push                w_push;
    t_row_out             w_first;
    t_row_out             w_second;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_width <= GRID_WIDTH_RESET;
        end else if (i_cfg_we) begin
            r_grid_width <= i_cfg_wdata;
        end
    end

    assign o_stall  = !w_room_two;
    assign w_accept = i_valid && w_room_two;

    // column mask and masked incoming row
    genvar c;
    generate
        for (c = 0; c < MAX_WIDTH; c++) begin : g_mask
            assign w_mask[c] = (CFG_BITS'(c) < r_grid_width);
        end
    endgenerate

    assign w_cur  = i_row.row_cells[MAX_WIDTH-1:0] & w_mask;
    assign w_up_a = (r_rows_seen == SEEN_TWO)  ? r_row_two_above : '0;
    assign w_up_b = (r_rows_seen != SEEN_NONE) ? r_row_above     : '0;

    // dead border padding on both sides
    assign w_pad_up_a  = {1'b0, w_up_a, 1'b0};
    assign w_pad_mid_a = {1'b0, r_row_above, 1'b0};
    assign w_pad_up_b  = {1'b0, w_up_b, 1'b0};
    assign w_pad_mid_b = {1'b0, w_cur, 1'b0};

    // lane array: one lane per column for each candidate result
    generate
        for (c = 0; c < MAX_WIDTH; c++) begin : g_lane
            lgrs_lane u_lane_above (
                .i_up    (w_pad_up_a[c+2:c]),
                .i_mid   (w_pad_mid_a[c+2:c]),
                .i_down  (w_pad_mid_b[c+2:c]),
                .o_alive (w_lanes_above[c])
            );
            lgrs_lane u_lane_cur (
                .i_up    (w_pad_up_b[c+2:c]),
                .i_mid   (w_pad_mid_b[c+2:c]),
                .i_down  (3'b000),
                .o_alive (w_lanes_cur[c])
            );
        end
    endgenerate

    lgrs_merge #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_merge (
        .i_accept      (w_accept),
        .i_is_last     (i_row.is_last_row),
        .i_rows_seen   (r_rows_seen),
        .i_mask        (w_mask),
        .i_lanes_above (w_lanes_above),
        .i_lanes_cur   (w_lanes_cur),
        .o_push        (w_push),
        .o_first       (w_first),
        .o_second      (w_second)
    );

    lgrs_out_fifo u_out_fifo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (w_push),
        .i_first    (w_first),
        .i_second   (w_second),
        .i_pop      (o_valid && !i_stall),
        .o_valid    (o_valid),
        .o_data     (o_res),
        .o_room_two (w_room_two)
    );

    // row history; cleared after the bottom row
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_above     <= '0;
            r_row_two_above <= '0;
            r_rows_seen     <= SEEN_NONE;
        end else if (w_accept) begin
            if (i_row.is_last_row) begin
                r_row_above     <= '0;
                r_row_two_above <= '0;
                r_rows_seen     <= SEEN_NONE;
            end else begin
                r_row_two_above <= r_row_above;
                r_row_above     <= w_cur;
                if (r_rows_seen != SEEN_TWO) begin
                    r_rows_seen <= 2'(r_rows_seen + 1'b1);
                end
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/lgrs_checker.sv @@
// ----------------------------------------------------------------------------
// lgrs_checker
// Port-level checks for the life generation row stream, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "life_generation_row_stream_assert.svh"

module lgrs_checker
    import lgrs_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_valid,
    input  wire logic     o_stall,
    input  wire t_row_in  i_row,
    input  wire logic     o_valid,
    input  wire logic     i_stall,
    input  wire t_row_out o_res,
    input  wire logic     i_cfg_we
);

    // a held result stays put
    `LGRS_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid && $stable(o_res))

    // nothing pending right after reset
    `LGRS_ASSERT_NOW(a_empty_after_reset, $past(!i_rst_n), !o_valid)

    // a bottom row always yields at least one result
    `LGRS_ASSERT_NEXT(a_last_gives_result, i_valid && !o_stall && i_row.is_last_row, o_valid)

    // input backpressure only while results are queued
    `LGRS_ASSERT_NOW(a_stall_needs_backlog, o_stall, o_valid)

    // width writes only land while both channels are quiet
    `LGRS_ASSERT_NOW(a_cfg_when_idle, i_cfg_we, !o_valid && !i_valid)

endmodule

bind life_generation_row_stream lgrs_checker u_lgrs_checker (.*);

`default_nettype wire

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top - life generation row stream testbench
// Streams grids through the block, one row per transaction, and checks each
// result against an in-bench B3/S23 predictor or a typed step's table rows.
// A directed table covers edge columns, lone and short grids, and the grid
// width corner cases. Random grids with mixed densities follow, interleaved
// with width updates. Both channels get random gaps and stalls.
// ----------------------------------------------------------------------------

module tb_top;
    import lgrs_pkg::*;

    localparam int GRID_MAX       = 64;
    localparam int IDLE_PCT       = 18;
    localparam int RAND_ITEMS     = 1730;
    localparam int CALM_FROM      = 600;
    localparam int CALM_TO        = 950;
    localparam int SETTLE_CYCLES  = 4;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;
    localparam logic [ROW_BITS-1:0] FULL_ROW = '1;

    // row content flavors for random grids
    typedef enum logic [2:0] {
        FILL_RANDOM,
        FILL_SPARSE,
        FILL_DENSE,
        FILL_EMPTY,
        FILL_FULL,
        FILL_MIXED
    } t_fill;

    // one directed step: optional width write, then one row
    typedef struct {
        logic                do_cfg;
        logic [CFG_BITS-1:0] cfg_val;
        logic [ROW_BITS-1:0] cells;
        logic                bottom;
        logic                typed;
        int                  n_typed;
        logic [ROW_BITS-1:0] want0;
        logic [ROW_BITS-1:0] want1;
    } t_plan_step;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_valid;
    logic                o_stall;
    t_row_in             i_row;
    logic                o_valid;
    logic                i_stall;
    t_row_out            o_res;
    logic                i_cfg_we;
    logic [CFG_BITS-1:0] i_cfg_wdata;

    // predictor state
    logic [CFG_BITS-1:0] width_cfg;
    logic [ROW_BITS-1:0] live_above;
    logic [ROW_BITS-1:0] live_two_above;
    logic [1:0]          rows_held;

    t_row_out expected_rows[$];
    t_row_out fresh_rows[$];
    int       bad_results;
    int       idle_cycles;
    logic     calm;

    t_plan_step plan[20];

    life_generation_row_stream uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_row       (i_row),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (o_res),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic logic [ROW_BITS-1:0] width_mask(input logic [CFG_BITS-1:0] w);
        if (w >= GRID_MAX)
            return '1;
        return (64'd1 << w) - 64'd1;
    endfunction

    // one B3/S23 step of the middle row, dead outside columns 0..63
    function automatic logic [ROW_BITS-1:0] next_gen(input logic [ROW_BITS-1:0] up,
                                                     input logic [ROW_BITS-1:0] mid,
                                                     input logic [ROW_BITS-1:0] dn,
                                                     input logic [ROW_BITS-1:0] mask);
        logic [ROW_BITS-1:0] res;
        int                  n;
        res = '0;
        for (int c = 0; c < ROW_BITS; c++) begin
            n = 0;
            for (int d = -1; d <= 1; d++) begin
                if (c + d >= 0 && c + d < ROW_BITS) begin
                    n += up[c+d] + dn[c+d];
                    if (d != 0)
                        n += mid[c+d];
                end
            end
            res[c] = (n == BORN_COUNT) || (mid[c] && n == SURVIVE_COUNT);
        end
        return res & mask;
    endfunction

    // advance the grid by one accepted row; results land in fresh_rows
    function automatic void grid_step(input t_row_in item);
        logic [ROW_BITS-1:0] mask;
        logic [ROW_BITS-1:0] cur;
        logic [ROW_BITS-1:0] up;
        t_row_out            res;
        mask = width_mask(width_cfg);
        cur  = item.row_cells & mask;
        fresh_rows.delete();
        if (rows_held >= SEEN_ONE) begin
            up = (rows_held >= SEEN_TWO) ? live_two_above : '0;
            res.next_row_cells = next_gen(up, live_above, cur, mask);
            res.last_of_grid   = 1'b0;
            fresh_rows.push_back(res);
        end
        if (item.is_last_row) begin
            up = (rows_held >= SEEN_ONE) ? live_above : '0;
            res.next_row_cells = next_gen(up, cur, '0, mask);
            res.last_of_grid   = 1'b1;
            fresh_rows.push_back(res);
            live_above     = '0;
            live_two_above = '0;
            rows_held      = SEEN_NONE;
        end else begin
            live_two_above = live_above;
            live_above     = cur;
            if (rows_held < SEEN_TWO)
                rows_held = rows_held + 2'd1;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [ROW_BITS-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [ROW_BITS-1:0] row_for(input t_fill fill);
        case (fill)
            FILL_SPARSE: return rand64() & rand64() & rand64();
            FILL_DENSE:  return rand64() | rand64();
            FILL_EMPTY:  return '0;
            FILL_FULL:   return '1;
            FILL_MIXED:  return row_for(t_fill'($urandom_range(4)));
            default:     return rand64();
        endcase
    endfunction

    function automatic logic [CFG_BITS-1:0] pick_width();
        case ($urandom_range(8))
            0:       return 7'd64;
            1:       return 7'd1;
            2:       return 7'd0;
            3:       return 7'd127;
            4:       return 7'd63;
            5:       return 7'd2;
            6:       return 7'($urandom_range(127, 65));
            default: return 7'($urandom_range(64, 3));
        endcase
    endfunction

    // send one row transaction and queue what it should produce
    task automatic send_row(input logic [ROW_BITS-1:0] cells, input logic bottom,
                            input logic typed, input int n_typed,
                            input logic [ROW_BITS-1:0] want0,
                            input logic [ROW_BITS-1:0] want1);
        t_row_in  item;
        t_row_out res;
        item.row_cells   = cells;
        item.is_last_row = bottom;
        if (!calm && $urandom_range(99) < IDLE_PCT) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < IDLE_PCT);
        end
        i_valid <= 1'b1;
        i_row   <= item;
        do @(posedge i_clk); while (o_stall);
        grid_step(item);
        if (typed) begin
            for (int k = 0; k < n_typed; k++) begin
                res.next_row_cells = (k == 0) ? want0 : want1;
                res.last_of_grid   = bottom && (k == n_typed - 1);
                expected_rows.push_back(res);
            end
        end else begin
            foreach (fresh_rows[k])
                expected_rows.push_back(fresh_rows[k]);
        end
    endtask

    // width update with the block idle
    task automatic write_width(input logic [CFG_BITS-1:0] w);
        i_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= w;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        width_cfg  = w;
    endtask

    task automatic log_bad(input string why, input t_row_out want, input t_row_out got);
        bad_results++;
        if (bad_results <= MAX_REPORTS)
            $display("%0t %s: expected %h last %0b, got %h last %0b", $time, why,
                     want.next_row_cells, want.last_of_grid,
                     got.next_row_cells, got.last_of_grid);
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------------
    initial begin
        plan = '{
            // lone full row: both end columns starve, interior survives on 2
            '{1'b0, 7'd0, FULL_ROW, 1'b1, 1'b1, 1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0},
            '{1'b0, 7'd0, 64'h0, 1'b1, 1'b1, 1, 64'h0, 64'h0},
            // three full rows: top row emits nothing
            '{1'b0, 7'd0, FULL_ROW, 1'b0, 1'b1, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, FULL_ROW, 1'b0, 1'b1, 1, 64'h8000_0000_0000_0001, 64'h0},
            '{1'b0, 7'd0, FULL_ROW, 1'b1, 1'b1, 2, 64'h0, 64'h8000_0000_0000_0001},
            // edge columns and stripes
            '{1'b0, 7'd0, 64'h0000_0000_0000_0007, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'h8000_0000_0000_0001, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'h5555_5555_5555_5555, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'hC000_0000_0000_0003, 1'b1, 1'b0, 0, 64'h0, 64'h0},
            // two-row grid holding a still block
            '{1'b0, 7'd0, 64'h0000_0000_0000_0006, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'h0000_0000_0000_0006, 1'b1, 1'b0, 0, 64'h0, 64'h0},
            // zero width kills everything
            '{1'b1, 7'd0, FULL_ROW, 1'b1, 1'b1, 1, 64'h0, 64'h0},
            // width above the maximum acts as full width
            '{1'b1, 7'd127, FULL_ROW, 1'b1, 1'b1, 1, 64'h7FFF_FFFF_FFFF_FFFE, 64'h0},
            // single column: a lone cell dies
            '{1'b1, 7'd1, FULL_ROW, 1'b1, 1'b1, 1, 64'h0, 64'h0},
            // narrow grid, then width changes in the middle of the grid
            '{1'b1, 7'd3, FULL_ROW, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, FULL_ROW, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b1, 7'd64, FULL_ROW, 1'b0, 1'b0, 0, 64'h0, 64'h0},
            '{1'b0, 7'd0, 64'hF0F0_0F0F_F0F0_0F0F, 1'b1, 1'b0, 0, 64'h0, 64'h0},
            '{1'b1, 7'd65, 64'h8000_0000_0000_0003, 1'b1, 1'b0, 0, 64'h0, 64'h0}
        };
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin
        int    sent;
        int    phase_end;
        int    height;
        t_fill fill;

        i_rst_n        <= 1'b0;
        i_valid        <= 1'b0;
        i_row          <= '0;
        i_cfg_we       <= 1'b0;
        i_cfg_wdata    <= '0;
        calm            = 1'b0;
        bad_results     = 0;
        width_cfg       = GRID_WIDTH_RESET;
        live_above      = '0;
        live_two_above  = '0;
        rows_held       = SEEN_NONE;

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (plan[k]) begin
            if (plan[k].do_cfg)
                write_width(plan[k].cfg_val);
            send_row(plan[k].cells, plan[k].bottom, plan[k].typed, plan[k].n_typed,
                     plan[k].want0, plan[k].want1);
        end

        // random grids; width updates may land between grids or mid-grid
        sent      = 0;
        phase_end = $urandom_range(250, 120);
        while (sent < RAND_ITEMS) begin
            height = ($urandom_range(9) == 0) ? $urandom_range(40, 12) : $urandom_range(6, 1);
            fill   = ($urandom_range(9) == 0) ? FILL_MIXED : t_fill'($urandom_range(4));
            for (int r = 0; r < height && sent < RAND_ITEMS; r++) begin
                if (sent == phase_end) begin
                    write_width(pick_width());
                    phase_end += $urandom_range(250, 120);
                end
                calm = (sent >= CALM_FROM && sent < CALM_TO);
                send_row(row_for(fill), r == height - 1, 1'b0, 0, '0, '0);
                sent++;
            end
        end

        i_valid <= 1'b0;
        while (expected_rows.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (bad_results == 0 && expected_rows.size() == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    // receiver stall, off during the calm stretch
    initial i_stall = 1'b0;
    always @(posedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end

    // result checker
    always @(posedge i_clk) begin
        t_row_out want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_rows.size() == 0) begin
                log_bad("unexpected result", '0, o_res);
            end else begin
                want = expected_rows.pop_front();
                if (o_res.next_row_cells !== want.next_row_cells ||
                    o_res.last_of_grid !== want.last_of_grid)
                    log_bad("result mismatch", want, o_res);
            end
        end
    end

    // watchdog: cycles with no transaction on either channel
    initial idle_cycles = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && !o_stall) || (o_valid && !i_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, idle_cycles);
            $display("Simulation FAILED");
            $finish;
        end
    end

endmodule
